// ----- rtl/stk_pkg.sv -----
// Shared types, constants and conversion helpers for the bounded stack block.
// No dependencies; every other file of the block imports this package.
package stk_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int OP_W       = 2;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 7;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   localparam cnt_type CNT_FULL = cnt_type'(DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_PURGE  = 2'd2,
      OP_INSERT = 2'd3
   } op_type;

   // one write port, one registered read port
   typedef struct packed {
      logic     we;
      addr_type waddr;
      data_type wdata;
      logic     re;
      addr_type raddr;
   } mem_req_type;

   typedef struct packed {
      logic gt;   // stored word greater than operand (signed)
      logic eq;
      logic neg;  // stored word negative
   } cmp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] popped_value;
      logic               popped_valid;
      logic               was_present;
      logic               overflow;
      logic [VALUE_W-1:0] top_value;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // input word to stored word: sign-extend or truncate
   function automatic data_type to_data(input logic signed [VALUE_W-1:0] v);
      return data_type'(v);
   endfunction

   // stored word to output word
   function automatic logic [VALUE_W-1:0] to_out(input data_type d);
      return VALUE_W'(signed'(d));
   endfunction

endpackage

// ----- rtl/stk_if.sv -----
// Valid/ready channel interfaces for the request and response transactions.
// Depends on stk_pkg for field widths.
interface stk_req_if import stk_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [VALUE_W-1:0] value;

   modport source (output valid, op, value, input ready);
   modport sink   (input valid, op, value, output ready);
endinterface

interface stk_rsp_if import stk_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] popped_value;
   logic               popped_valid;
   logic               was_present;
   logic               overflow;
   logic [VALUE_W-1:0] top_value;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, popped_value, popped_valid, was_present, overflow,
                   top_value, entry_count, input ready);
   modport sink   (input valid, popped_value, popped_valid, was_present, overflow,
                   top_value, entry_count, output ready);
endinterface

// ----- rtl/stk_store.sv -----
// Entry store: DEPTH words, one write port and one read port with registered data.
// Depends on stk_pkg.
module stk_store import stk_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output data_type    rdata
);

   data_type mem [DEPTH];
   data_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/stk_cmp.sv -----
// Shared compare unit: signed greater, equal and sign test of one stored word.
// Depends on stk_pkg.
module stk_cmp import stk_pkg::*; (
   input  data_type entry,
   input  data_type operand,
   output cmp_type  cmp
);

   always_comb begin
      cmp.gt  = $signed(entry) > $signed(operand);
      cmp.eq  = entry == operand;
      cmp.neg = entry[DATA_WIDTH-1];
   end

endmodule

// ----- rtl/stk_seq.sv -----
// Sequencer: walks the entry store one word a cycle for each operation.
// Depends on stk_pkg; drives stk_store and reads stk_cmp.
module stk_seq import stk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  op_type      start_op,
   input  data_type    start_value,
   output logic        busy,
   output logic        done,
   output rsp_type     result,
   output mem_req_type mem_req,
   input  data_type    rdata,
   input  cmp_type     cmp,
   output data_type    operand
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_POP   = 6'b000010,
      S_PURGE = 6'b000100,
      S_SCAN  = 6'b001000,
      S_SHIFT = 6'b010000,
      S_PLACE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   data_type  top_ff, top_in;
   data_type  val_ff, val_in;
   data_type  last_ff, last_in;
   cnt_type   ptr_ff, ptr_in;   // scan/shift/purge read pointer
   cnt_type   wr_ff, wr_in;     // purge write pointer, insert position

   assign busy    = state_ff != S_IDLE;
   assign operand = val_ff;

   always_comb begin
      cnt_type cnt_inc;
      cnt_type cnt_dec;
      cnt_type cnt_dec2;
      cnt_type ptr_inc;
      cnt_type ptr_dec;
      cnt_type ptr_dec2;
      cnt_type wr_inc;
      cnt_type ins;
      logic    decide;

      cnt_inc  = count_ff + cnt_type'(1);
      cnt_dec  = count_ff - cnt_type'(1);
      cnt_dec2 = count_ff - cnt_type'(2);
      ptr_inc  = ptr_ff + cnt_type'(1);
      ptr_dec  = ptr_ff - cnt_type'(1);
      ptr_dec2 = ptr_ff - cnt_type'(2);
      wr_inc   = wr_ff + cnt_type'(1);
      ins      = cmp.gt ? '0 : ptr_ff;
      decide   = 1'b0;

      state_in = state_ff;
      count_in = count_ff;
      top_in   = top_ff;
      val_in   = val_ff;
      last_in  = last_ff;
      ptr_in   = ptr_ff;
      wr_in    = wr_ff;
      mem_req  = '0;
      done     = 1'b0;
      result   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in = start_value;
               unique case (start_op)
                  OP_PUSH: begin
                     done = 1'b1;
                     if (count_ff == CNT_FULL) begin
                        result.overflow = 1'b1;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_ff[ADDR_W-1:0];
                        mem_req.wdata = start_value;
                        count_in      = cnt_inc;
                        top_in        = start_value;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        done = 1'b1;
                     end else begin
                        count_in = cnt_dec;
                        if (cnt_dec == '0) begin
                           done                = 1'b1;
                           result.popped_value = to_out(top_ff);
                           result.popped_valid = 1'b1;
                        end else begin
                           mem_req.re    = 1'b1;
                           mem_req.raddr = cnt_dec2[ADDR_W-1:0];
                           state_in      = S_POP;
                        end
                     end
                  end
                  OP_PURGE: begin
                     if (count_ff == '0) begin
                        done = 1'b1;
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = '0;
                        ptr_in        = cnt_type'(1);
                        wr_in         = '0;
                        state_in      = S_PURGE;
                     end
                  end
                  OP_INSERT: begin
                     if (count_ff == '0) begin
                        done          = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.waddr = '0;
                        mem_req.wdata = start_value;
                        count_in      = cnt_inc;
                        top_in        = start_value;
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = cnt_dec[ADDR_W-1:0];
                        ptr_in        = count_ff;
                        state_in      = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_POP: begin
            // old top goes out, word just read becomes the new top
            done                = 1'b1;
            result.popped_value = to_out(top_ff);
            result.popped_valid = 1'b1;
            top_in              = rdata;
            state_in            = S_IDLE;
         end

         S_PURGE: begin
            // rdata holds entry ptr_ff-1; compact non-negative words down to wr_ff
            if (!cmp.neg) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = wr_ff[ADDR_W-1:0];
               mem_req.wdata = rdata;
               last_in       = rdata;
               wr_in         = wr_inc;
            end
            if (ptr_ff == count_ff) begin
               done     = 1'b1;
               count_in = cmp.neg ? wr_ff : wr_inc;
               top_in   = cmp.neg ? last_ff : rdata;
               state_in = S_IDLE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = ptr_ff[ADDR_W-1:0];
               ptr_in        = ptr_inc;
            end
         end

         S_SCAN: begin
            // rdata holds entry ptr_ff-1, compared against the operand
            if (cmp.gt) begin
               if (ptr_ff == cnt_type'(1)) begin
                  decide = 1'b1;
               end else begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = ptr_dec2[ADDR_W-1:0];
                  ptr_in        = ptr_dec;
               end
            end else if (cmp.eq) begin
               done               = 1'b1;
               result.was_present = 1'b1;
               state_in           = S_IDLE;
            end else begin
               decide = 1'b1;
            end
            if (decide) begin
               if (count_ff == CNT_FULL) begin
                  done            = 1'b1;
                  result.overflow = 1'b1;
                  state_in        = S_IDLE;
               end else if (ins == count_ff) begin
                  done          = 1'b1;
                  mem_req.we    = 1'b1;
                  mem_req.waddr = count_ff[ADDR_W-1:0];
                  mem_req.wdata = val_ff;
                  count_in      = cnt_inc;
                  top_in        = val_ff;
                  state_in      = S_IDLE;
               end else begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = cnt_dec[ADDR_W-1:0];
                  ptr_in        = cnt_dec;
                  wr_in         = ins;
                  state_in      = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            // move entry ptr_ff up one slot, top first
            mem_req.we    = 1'b1;
            mem_req.waddr = ptr_inc[ADDR_W-1:0];
            mem_req.wdata = rdata;
            if (ptr_ff == wr_ff) begin
               state_in = S_PLACE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = ptr_dec[ADDR_W-1:0];
               ptr_in        = ptr_dec;
            end
         end

         S_PLACE: begin
            done          = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.waddr = wr_ff[ADDR_W-1:0];
            mem_req.wdata = val_ff;
            count_in      = cnt_inc;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      result.top_value   = (count_in == '0) ? '0 : to_out(top_in);
      result.entry_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      val_ff  <= val_in;
      last_ff <= last_in;
      ptr_ff  <= ptr_in;
      wr_ff   <= wr_in;
   end

endmodule

// ----- rtl/stack_with_sorted_insert_and_purge.sv -----
// Bounded stack of DEPTH signed words (64 x 32 bits) with push, pop, purge of
// negative entries and sorted insert. One request transaction gives exactly one
// response transaction. Requests are taken one at a time: the block is ready
// only while the sequencer is idle and the response register is free or being
// emptied. The single-read-port entry store is walked one word a cycle: push
// writes the word directly; pop ends directly when it leaves the stack empty,
// else it reads the new top back; purge reads every entry and compacts the
// non-negative ones down; sorted insert writes directly on an empty stack,
// otherwise it scans down from the top past every word greater than the operand
// and stops at the first word not greater, then shifts the words above the
// insert slot up one and places it; an equal word or a full store stops it.
// No clearing pass follows reset: slots at or above the count are never read.
// Depends on stk_pkg, stk_if, stk_store, stk_cmp and stk_seq.
module stack_with_sorted_insert_and_purge import stk_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   stk_req_if.sink    req_chan,
   stk_rsp_if.source  rsp_chan
);

   mem_req_type mem_req;
   data_type    rdata;
   data_type    operand;
   cmp_type     cmp;
   logic        start;
   logic        busy;
   logic        done;
   rsp_type     result;

   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // new transaction only when idle and the response slot is free next edge
   assign req_chan.ready = !busy && (!rsp_valid_ff || rsp_chan.ready);
   assign start          = req_chan.valid && req_chan.ready;

   stk_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   // the one comparator shared by purge (sign) and insert (greater/equal)
   stk_cmp u_cmp (
      .entry   (rdata),
      .operand (operand),
      .cmp     (cmp)
   );

   stk_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_op    (op_type'(req_chan.op)),
      .start_value (to_data(req_chan.value)),
      .busy        (busy),
      .done        (done),
      .result      (result),
      .mem_req     (mem_req),
      .rdata       (rdata),
      .cmp         (cmp),
      .operand     (operand)
   );

   // response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = rsp_ff.popped_value;
   assign rsp_chan.popped_valid = rsp_ff.popped_valid;
   assign rsp_chan.was_present  = rsp_ff.was_present;
   assign rsp_chan.overflow     = rsp_ff.overflow;
   assign rsp_chan.top_value    = rsp_ff.top_value;
   assign rsp_chan.entry_count  = rsp_ff.entry_count;

endmodule

// ----- bench/stack_with_sorted_insert_and_purge_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the bounded stack: a directed table, then random op mixes.
// Responses are checked against a stack predictor in this file.
// Depends on stk_pkg, stk_if and the stack_with_sorted_insert_and_purge top level.
module stack_with_sorted_insert_and_purge_test;
   import stk_pkg::*;

   // cycles with no transaction on either channel before the run is called hung;
   // worst legal gap is a full-depth sorted insert plus a short response stall
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1080;
   localparam int DRAIN_CYCLES = 200;
   // random items in this window run with both sides never idling
   localparam int STEADY_FIRST = 300;
   localparam int STEADY_LAST  = 520;

   typedef logic signed [DATA_WIDTH-1:0] word_type;

   // one row of stimulus; want is used only when typed is set
   typedef struct {
      op_type             op;
      logic [VALUE_W-1:0] value;
      bit                 typed;
      rsp_type            want;
   } stim_row_type;

   // op mixes for the random part
   typedef enum {MIX_FILL, MIX_DRAIN, MIX_SORTED, MIX_ANY} mix_type;

   logic clock;
   logic reset;
   bit   steady;
   int   failures = 0;

   stk_req_if req_chan();
   stk_rsp_if rsp_chan();

   stack_with_sorted_insert_and_purge dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicted stack contents, slot 0 at the bottom
   word_type stack_words[DEPTH];
   int       stack_depth;

   // responses still owed by the block, oldest first
   rsp_type  pending_rsp[$];

   stim_row_type directed_rows[$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one operation to the predicted stack and returns its response.
   function automatic rsp_type apply_stack_op(input op_type op,
                                              input logic [VALUE_W-1:0] value);
      rsp_type  r;
      word_type w;
      int       pos;
      int       kept;
      r = '0;
      w = word_type'(signed'(value));
      case (op)
         OP_PUSH: begin
            if (stack_depth >= DEPTH) begin
               r.overflow = 1'b1;
            end else begin
               stack_words[stack_depth] = w;
               stack_depth++;
            end
         end
         OP_POP: begin
            if (stack_depth > 0) begin
               stack_depth--;
               r.popped_value = VALUE_W'(stack_words[stack_depth]);
               r.popped_valid = 1'b1;
            end
         end
         OP_PURGE: begin
            // compact the non-negative words downward, order kept
            kept = 0;
            for (int i = 0; i < stack_depth; i++) begin
               if (!stack_words[i][DATA_WIDTH-1]) begin
                  stack_words[kept] = stack_words[i];
                  kept++;
               end
            end
            stack_depth = kept;
         end
         default: begin
            // scan from the top past every word greater than the operand;
            // an equal word there wins over a full store
            pos = stack_depth;
            while (pos > 0 && stack_words[pos-1] > w)
               pos--;
            if (pos > 0 && stack_words[pos-1] == w) begin
               r.was_present = 1'b1;
            end else if (stack_depth >= DEPTH) begin
               r.overflow = 1'b1;
            end else begin
               for (int j = stack_depth; j > pos; j--)
                  stack_words[j] = stack_words[j-1];
               stack_words[pos] = w;
               stack_depth++;
            end
         end
      endcase
      r.top_value   = (stack_depth > 0) ? VALUE_W'(stack_words[stack_depth-1]) : '0;
      r.entry_count = COUNT_W'(stack_depth);
      return r;
   endfunction

   function automatic stim_row_type make_row(input op_type op,
                                             input logic [VALUE_W-1:0] value);
      stim_row_type row;
      row.op    = op;
      row.value = value;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   // row whose response is written out by hand
   function automatic stim_row_type make_typed_row(input op_type op,
                                              input logic [VALUE_W-1:0] value,
                                              input logic [VALUE_W-1:0] popped_value,
                                              input logic popped_valid,
                                              input logic was_present,
                                              input logic overflow,
                                              input logic [VALUE_W-1:0] top_value,
                                              input logic [COUNT_W-1:0] entry_count);
      stim_row_type row;
      row = make_row(op, value);
      row.typed             = 1'b1;
      row.want.popped_value = popped_value;
      row.want.popped_valid = popped_valid;
      row.want.was_present  = was_present;
      row.want.overflow     = overflow;
      row.want.top_value    = top_value;
      row.want.entry_count  = entry_count;
      return row;
   endfunction

   function automatic op_type pick_op(input mix_type mix);
      int unsigned roll;
      roll = $urandom_range(99);
      case (mix)
         MIX_FILL: begin
            if (roll < 50) return OP_PUSH;
            if (roll < 85) return OP_INSERT;
            if (roll < 95) return OP_POP;
            return OP_PURGE;
         end
         MIX_DRAIN: begin
            if (roll < 15) return OP_PUSH;
            if (roll < 25) return OP_INSERT;
            if (roll < 88) return OP_POP;
            return OP_PURGE;
         end
         MIX_SORTED: begin
            // mostly inserts, which keep the stack ordered, so the scan runs deep
            if (roll < 82) return OP_INSERT;
            if (roll < 92) return OP_POP;
            if (roll < 96) return OP_PURGE;
            return OP_PUSH;
         end
         default: return op_type'($urandom_range(3));
      endcase
   endfunction

   // small values make equal-entry hits common; extremes and full-range
   // words exercise the signed compare and every data bit
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned roll;
      int          small_value;
      roll = $urandom_range(99);
      if (roll < 45) begin
         small_value = int'($urandom_range(80)) - 40;
         return VALUE_W'(small_value);
      end
      if (roll < 60) begin
         case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h8000_0001;
            default: return 32'h7FFF_FFFE;
         endcase
      end
      return $urandom;
   endfunction

   // Drives one request transaction, with random idle cycles before it, and
   // records the response it must produce once the block takes it.
   task automatic send_request(input stim_row_type row);
      rsp_type predicted;
      while (!steady && $urandom_range(99) < 15) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= row.op;
      req_chan.value <= row.value;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predicted = apply_stack_op(row.op, row.value);
      pending_rsp.push_back(row.typed ? row.want : predicted);
      @(negedge clock);
   endtask

   task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endtask

   // response side: random back-pressure, changed at the falling edge
   initial begin : rsp_drive
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !reset && (steady || $urandom_range(99) >= 15);
      end
   end

   // response checker, sampled at the rising edge
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response transaction with none pending");
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            compare_field("popped_value", want.popped_value, rsp_chan.popped_value);
            compare_field("popped_valid", VALUE_W'(want.popped_valid),
                          VALUE_W'(rsp_chan.popped_valid));
            compare_field("was_present", VALUE_W'(want.was_present),
                          VALUE_W'(rsp_chan.was_present));
            compare_field("overflow", VALUE_W'(want.overflow), VALUE_W'(rsp_chan.overflow));
            compare_field("top_value", want.top_value, rsp_chan.top_value);
            compare_field("entry_count", VALUE_W'(want.entry_count),
                          VALUE_W'(rsp_chan.entry_count));
         end
      end
   end

   // hang detector: too many cycles in a row without any transaction
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      mix_type mix;
      int      burst;
      int      sent;
      steady         = 1'b0;
      stack_depth    = 0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op    = OP_PUSH;
      req_chan.value = '0;

      // Directed table. Typed rows have responses readable at a glance; the
      // rest go through the predictor.
      // empty stack: pop and purge change nothing
      directed_rows.push_back(make_typed_row(OP_POP,    32'h0, '0, 0, 0, 0, '0, 0));
      directed_rows.push_back(make_typed_row(OP_PURGE,  32'h0, '0, 0, 0, 0, '0, 0));
      // insert on empty becomes the only entry
      directed_rows.push_back(make_typed_row(OP_INSERT, 32'hFFFF_FFFB, '0, 0, 0, 0,
                                             32'hFFFF_FFFB, 1));
      // signed extremes
      directed_rows.push_back(make_typed_row(OP_PUSH,   32'h7FFF_FFFF, '0, 0, 0, 0,
                                             32'h7FFF_FFFF, 2));
      directed_rows.push_back(make_typed_row(OP_PUSH,   32'h8000_0000, '0, 0, 0, 0,
                                             32'h8000_0000, 3));
      // most negative word already on top: found, stack unchanged
      directed_rows.push_back(make_typed_row(OP_INSERT, 32'h8000_0000, '0, 0, 1, 0,
                                             32'h8000_0000, 3));
      // purge drops both negatives, operand ignored
      directed_rows.push_back(make_typed_row(OP_PURGE,  32'hFFFF_FFFF, '0, 0, 0, 0,
                                             32'h7FFF_FFFF, 1));
      directed_rows.push_back(make_typed_row(OP_POP,    32'h1234_5678, 32'h7FFF_FFFF, 1, 0, 0,
                                             '0, 0));
      // build an ordered stack, largest on top, and insert through it
      directed_rows.push_back(make_row(OP_PUSH,   32'd0));
      directed_rows.push_back(make_row(OP_PUSH,   32'd10));
      directed_rows.push_back(make_row(OP_PUSH,   32'd100));
      directed_rows.push_back(make_row(OP_INSERT, 32'd10));
      directed_rows.push_back(make_row(OP_INSERT, 32'd50));
      directed_rows.push_back(make_row(OP_INSERT, 32'd1000));
      directed_rows.push_back(make_row(OP_INSERT, 32'hFFFF_FFFD));
      // unsorted top: scan stops at the first word not greater than the operand
      directed_rows.push_back(make_row(OP_PUSH,   32'hFFFF_FFF9));
      directed_rows.push_back(make_row(OP_INSERT, 32'd3));
      directed_rows.push_back(make_row(OP_INSERT, 32'hFFFF_FFF9));
      directed_rows.push_back(make_row(OP_PURGE,  32'hA5A5_A5A5));
      directed_rows.push_back(make_row(OP_POP,    32'hFFFF_FFFF));
      directed_rows.push_back(make_row(OP_POP,    32'd0));
      directed_rows.push_back(make_row(OP_INSERT, 32'd0));
      directed_rows.push_back(make_row(OP_INSERT, 32'hFFFF_FFFF));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i]);

      // Random part: bursts of one op mix each. Fill bursts run the store into
      // overflow, sorted bursts give deep scans and equal hits on a full store.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mix   = mix_type'($urandom_range(3));
         burst = $urandom_range(90, 20);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            steady = (sent >= STEADY_FIRST && sent < STEADY_LAST);
            send_request(make_row(pick_op(mix), pick_value()));
            sent++;
         end
      end
      req_chan.valid <= 1'b0;
      steady = 1'b0;

      // watchdog bounds this wait
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
